### rtl/bracket_balance_checker_unit_assert.svh
// ----------------------------------------------------------------------------
// bracket_balance_checker_unit_assert.svh
// Assertion macros used by the bracket checker RTL.
// ----------------------------------------------------------------------------
`ifndef BRACKET_BALANCE_CHECKER_UNIT_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bbc assertion failed");

// next-cycle implication, checked outside reset
`define BBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bbc assertion failed");

`endif

### rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Types, character constants and byte decode for the bracket checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

	typedef logic [1:0] closer_t;

	localparam closer_t CODE_ROUND  = 2'd0;
	localparam closer_t CODE_SQUARE = 2'd1;
	localparam closer_t CODE_CURLY  = 2'd2;

	localparam logic [7:0] CHAR_LROUND  = 8'h28; // (
	localparam logic [7:0] CHAR_RROUND  = 8'h29; // )
	localparam logic [7:0] CHAR_LSQUARE = 8'h5B; // [
	localparam logic [7:0] CHAR_RSQUARE = 8'h5D; // ]
	localparam logic [7:0] CHAR_LCURLY  = 8'h7B; // {
	localparam logic [7:0] CHAR_RCURLY  = 8'h7D; // }

	// shift control for the cell chain
	typedef struct packed {
		logic push;
		logic pop;
	} stack_op_t;

	typedef struct packed {
		logic    opener;
		logic    closer;
		closer_t code;
	} decode_t;

	function automatic decode_t decode_byte(logic [7:0] b);
		decode_t d;
		d = '{opener: 1'b0, closer: 1'b0, code: CODE_ROUND};
		case (b)
			CHAR_LROUND: begin
				d.opener = 1'b1;
				d.code   = CODE_ROUND;
			end
			CHAR_LSQUARE: begin
				d.opener = 1'b1;
				d.code   = CODE_SQUARE;
			end
			CHAR_LCURLY: begin
				d.opener = 1'b1;
				d.code   = CODE_CURLY;
			end
			CHAR_RROUND: begin
				d.closer = 1'b1;
				d.code   = CODE_ROUND;
			end
			CHAR_RSQUARE: begin
				d.closer = 1'b1;
				d.code   = CODE_SQUARE;
			end
			CHAR_RCURLY: begin
				d.closer = 1'b1;
				d.code   = CODE_CURLY;
			end
			default: begin
				d.opener = 1'b0;
			end
		endcase
		return d;
	endfunction

endpackage

### rtl/bbc_if.sv
// ----------------------------------------------------------------------------
// bbc_if
// Valid/ready channels: text bytes in, verdict words out.
// ----------------------------------------------------------------------------
interface bbc_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       is_last;

	modport source (output valid, output text_byte, output is_last, input ready);
	modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

interface bbc_verdict_if;
	logic valid;
	logic ready;
	logic balanced;
	logic overflowed;

	modport source (output valid, output balanced, output overflowed, input ready);
	modport sink   (input valid, input balanced, input overflowed, output ready);
endinterface

### rtl/bbc_cell.sv
// ----------------------------------------------------------------------------
// bbc_cell
// One stack slot: loads from the slot above on push, from below on pop.
// ----------------------------------------------------------------------------
module bbc_cell
	import bbc_pkg::*;
(
	input  logic      clk,
	input  stack_op_t op,
	input  closer_t   from_above,
	input  closer_t   from_below,
	output closer_t   code
);

	closer_t code_q;

	always_ff @(posedge clk) begin
		if (op.push) begin
			code_q <= from_above;
		end else if (op.pop) begin
			code_q <= from_below;
		end
	end

	assign code = code_q;

endmodule

### rtl/bracket_balance_checker_unit.sv
// The last byte registers its verdict in the output word, or in the skid word
// while that one waits. One byte per cycle is taken while the skid word is
// empty; every cell shifts in the same cycle on push or pop, and the match
// compare against cell 0 plus the level update is the per-byte path. The main
// and skid output words keep input flowing while one verdict waits. Reset
// clears level, error flags and output valids; the stack cells are not reset.
`include "bracket_balance_checker_unit_assert.svh"

// ----------------------------------------------------------------------------
// bracket_balance_checker_unit
// Bracket balance checker built on a shifting chain of stack cells.
// ----------------------------------------------------------------------------
module bracket_balance_checker_unit
	import bbc_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	bbc_text_if.sink      chars,
	bbc_verdict_if.source verdict
);

	localparam int LVL_W = $clog2(STACK_DEPTH + 1);
	localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);

	logic [LVL_W-1:0] level_q;
	logic             mismatch_q;
	logic             overflow_q;

	logic out_valid_q, out_bal_q, out_ovf_q;
	logic skid_full_q, skid_bal_q, skid_ovf_q;

	closer_t   cell_code [STACK_DEPTH];
	stack_op_t op;
	decode_t   dec;

	logic             take;
	logic             empty, full, hit;
	logic [LVL_W-1:0] level_nx;
	logic             mismatch_nx, overflow_nx;
	logic             res_new, res_bal;
	logic             out_fire;

	assign chars.ready = !skid_full_q;
	assign take        = chars.valid && chars.ready;

	always_comb begin
		dec         = decode_byte(chars.text_byte);
		empty       = (level_q == '0);
		full        = (level_q == LVL_FULL);
		hit         = !empty && (cell_code[0] == dec.code);
		op.push     = take && dec.opener && !full;
		op.pop      = take && dec.closer && hit;
		level_nx    = level_q;
		mismatch_nx = mismatch_q;
		overflow_nx = overflow_q;
		if (op.push) begin
			level_nx = level_q + LVL_W'(1);
		end else if (op.pop) begin
			level_nx = level_q - LVL_W'(1);
		end
		if (take && dec.opener && full) begin
			overflow_nx = 1'b1;
		end
		if (take && dec.closer && !hit) begin
			mismatch_nx = 1'b1;
		end
		res_new = take && chars.is_last;
		res_bal = !mismatch_nx && !overflow_nx && (level_nx == '0);
	end

	// cell chain: cell 0 is the top of stack
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		closer_t above, below;
		if (i == 0) begin : g_top
			assign above = dec.code;
		end else begin : g_mid
			assign above = cell_code[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bot
			assign below = cell_code[i];
		end else begin : g_up
			assign below = cell_code[i+1];
		end
		bbc_cell u_cell (
			.clk        (clk),
			.op         (op),
			.from_above (above),
			.from_below (below),
			.code       (cell_code[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= '0;
			mismatch_q <= 1'b0;
			overflow_q <= 1'b0;
		end else if (take) begin
			if (chars.is_last) begin
				level_q    <= '0;
				mismatch_q <= 1'b0;
				overflow_q <= 1'b0;
			end else begin
				level_q    <= level_nx;
				mismatch_q <= mismatch_nx;
				overflow_q <= overflow_nx;
			end
		end
	end

	// output word plus skid word
	assign out_fire = out_valid_q && verdict.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (out_fire) begin
				skid_full_q <= 1'b0;
			end
		end else if (res_new) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_full_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (out_fire) begin
				out_bal_q <= skid_bal_q;
				out_ovf_q <= skid_ovf_q;
			end
		end else if (res_new) begin
			if (!out_valid_q || out_fire) begin
				out_bal_q <= res_bal;
				out_ovf_q <= overflow_nx;
			end else begin
				skid_bal_q <= res_bal;
				skid_ovf_q <= overflow_nx;
			end
		end
	end

	assign verdict.valid      = out_valid_q;
	assign verdict.balanced   = out_bal_q;
	assign verdict.overflowed = out_ovf_q;

	`BBC_ASSERT_NOW(a_level_bound, clk, arst_n, 1'b1, level_q <= LVL_FULL)
	`BBC_ASSERT_NOW(a_skid_behind_out, clk, arst_n, skid_full_q, out_valid_q)
	`BBC_ASSERT_NEXT(a_clear_after_last, clk, arst_n, take && chars.is_last,
		level_q == '0 && !mismatch_q && !overflow_q)
	`BBC_ASSERT_NOW(a_ovf_not_bal, clk, arst_n, out_valid_q, !(out_bal_q && out_ovf_q))
	`BBC_ASSERT_NOW(a_no_push_pop, clk, arst_n, 1'b1, !(op.push && op.pop))

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for bracket_balance_checker_unit. Strings of text bytes go in
// through the chars channel. The bench keeps its own copy of the bracket
// stack to work out the verdict for each string, and checks every verdict
// word in order. Most strings are well nested with random content. Some carry
// flaws, some are raw noise, and a few climb to the full stack depth or past
// it. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bbc_pkg::*;

	localparam int STACK_DEPTH = 64;
	localparam int RANDOM_BYTES = 900;
	localparam int CALM_TAIL = 250;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_last;
	} text_word_t;

	typedef struct packed {
		logic balanced;
		logic overflowed;
	} verdict_word_t;

	typedef enum int {FLAW_NONE, FLAW_SWAP, FLAW_DROP, FLAW_EXTRA, FLAW_LEAD} flaw_t;

	logic clk;
	logic arst_n;

	bbc_text_if    chars_if();
	bbc_verdict_if verdict_if();

	bracket_balance_checker_unit #(.STACK_DEPTH(STACK_DEPTH)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.verdict (verdict_if)
	);

	text_word_t    text_q[$];
	verdict_word_t verdict_q[$];
	int            errors;
	int            idle_left;
	int            stall_left;

	// shadow of the bracket stack
	closer_t     nest_stack[STACK_DEPTH];
	int unsigned nest_level;
	bit          nest_mismatch;
	bit          nest_overflow;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb: errors");
		$finish;
	end

	function automatic logic [7:0] opener_char(closer_t code);
		case (code)
			CODE_ROUND:  return CHAR_LROUND;
			CODE_SQUARE: return CHAR_LSQUARE;
			default:     return CHAR_LCURLY;
		endcase
	endfunction

	function automatic logic [7:0] closer_char(closer_t code);
		case (code)
			CODE_ROUND:  return CHAR_RROUND;
			CODE_SQUARE: return CHAR_RSQUARE;
			default:     return CHAR_RCURLY;
		endcase
	endfunction

	function automatic bit is_bracket(logic [7:0] b);
		return b == CHAR_LROUND || b == CHAR_RROUND || b == CHAR_LSQUARE ||
			b == CHAR_RSQUARE || b == CHAR_LCURLY || b == CHAR_RCURLY;
	endfunction

	function automatic logic [7:0] filler_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (is_bracket(b));
		return b;
	endfunction

	// advance the shadow stack by one accepted word; queue a verdict on last
	function automatic void track_brackets(logic [7:0] b, logic last);
		bit            opens;
		bit            closes;
		closer_t       code;
		verdict_word_t v;
		opens = 1'b0;
		closes = 1'b0;
		code = CODE_ROUND;
		case (b)
			CHAR_LROUND: begin opens = 1'b1; code = CODE_ROUND; end
			CHAR_LSQUARE: begin opens = 1'b1; code = CODE_SQUARE; end
			CHAR_LCURLY: begin opens = 1'b1; code = CODE_CURLY; end
			CHAR_RROUND: begin closes = 1'b1; code = CODE_ROUND; end
			CHAR_RSQUARE: begin closes = 1'b1; code = CODE_SQUARE; end
			CHAR_RCURLY: begin closes = 1'b1; code = CODE_CURLY; end
			default: begin end
		endcase
		if (opens) begin
			if (nest_level >= STACK_DEPTH)
				nest_overflow = 1'b1;
			else begin
				nest_stack[nest_level] = code;
				nest_level++;
			end
		end else if (closes) begin
			if (nest_level == 0 || nest_stack[nest_level - 1] != code)
				nest_mismatch = 1'b1;
			else
				nest_level--;
		end
		if (last) begin
			v.balanced = !nest_mismatch && !nest_overflow && nest_level == 0;
			v.overflowed = nest_overflow;
			verdict_q.push_back(v);
			nest_level = 0;
			nest_mismatch = 1'b0;
			nest_overflow = 1'b0;
		end
	endfunction

	task automatic queue_bytes(input logic [7:0] s[$]);
		text_word_t w;
		foreach (s[i]) begin
			w.text_byte = s[i];
			w.is_last = (i == s.size() - 1);
			text_q.push_back(w);
		end
	endtask

	// nested string with random content; climb forces a run of openers first
	task automatic queue_nested(input int unsigned peak, input bit climb, input flaw_t flaw);
		closer_t     open_codes[$];
		logic [7:0]  s[$];
		int unsigned steps;
		int unsigned k;
		closer_t     c;
		closer_t     other;
		if (climb) begin
			repeat (peak) begin
				c = closer_t'($urandom_range(0, 2));
				open_codes.push_back(c);
				s.push_back(opener_char(c));
			end
		end
		steps = $urandom_range(1, 2 * peak + 4);
		repeat (steps) begin
			if (open_codes.size() < peak && $urandom_range(0, 1)) begin
				c = closer_t'($urandom_range(0, 2));
				open_codes.push_back(c);
				s.push_back(opener_char(c));
			end else if (open_codes.size() > 0 && $urandom_range(0, 2) != 0)
				s.push_back(closer_char(open_codes.pop_back()));
			else
				s.push_back(filler_byte());
		end
		while (open_codes.size() > 0)
			s.push_back(closer_char(open_codes.pop_back()));
		if (s.size() == 0)
			s.push_back(filler_byte());
		case (flaw)
			FLAW_SWAP: begin
				// turn one closer into a different one
				k = $urandom_range(0, s.size() - 1);
				for (int i = k; i < s.size(); i++) begin
					if (s[i] == CHAR_RROUND || s[i] == CHAR_RSQUARE || s[i] == CHAR_RCURLY) begin
						do other = closer_t'($urandom_range(0, 2));
						while (closer_char(other) == s[i]);
						s[i] = closer_char(other);
						break;
					end
				end
			end
			FLAW_DROP: if (s.size() > 1) void'(s.pop_back());
			FLAW_EXTRA: s.push_back(closer_char(closer_t'($urandom_range(0, 2))));
			FLAW_LEAD: s.push_front(closer_char(closer_t'($urandom_range(0, 2))));
			default: begin end
		endcase
		queue_bytes(s);
	endtask

	task automatic queue_noise();
		logic [7:0] s[$];
		logic [7:0] pick[6];
		pick = '{CHAR_LROUND, CHAR_RROUND, CHAR_LSQUARE, CHAR_RSQUARE, CHAR_LCURLY, CHAR_RCURLY};
		repeat ($urandom_range(1, 12)) begin
			if ($urandom_range(0, 1))
				s.push_back(pick[$urandom_range(0, 5)]);
			else
				s.push_back(8'($urandom));
		end
		queue_bytes(s);
	endtask

	// exactly d openers of one kind, then c matching closers
	task automatic queue_tower(input int unsigned d, input int unsigned c, input closer_t code);
		logic [7:0] s[$];
		repeat (d) s.push_back(opener_char(code));
		repeat (c) s.push_back(closer_char(code));
		queue_bytes(s);
	endtask

	task automatic wait_idle();
		while (text_q.size() != 0 || chars_if.valid || verdict_q.size() != 0)
			@(posedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_if.valid <= 1'b0;
			chars_if.text_byte <= 8'h00;
			chars_if.is_last <= 1'b0;
			idle_left = 0;
		end else begin
			if (chars_if.valid && chars_if.ready)
				track_brackets(chars_if.text_byte, chars_if.is_last);
			if (!chars_if.valid || chars_if.ready) begin
				if (idle_left > 0) begin
					idle_left--;
					chars_if.valid <= 1'b0;
				end else if (text_q.size() == 0)
					chars_if.valid <= 1'b0;
				else if (text_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
					idle_left = $urandom_range(0, 4);
					chars_if.valid <= 1'b0;
				end else begin
					chars_if.valid <= 1'b1;
					chars_if.text_byte <= text_q[0].text_byte;
					chars_if.is_last <= text_q[0].is_last;
					void'(text_q.pop_front());
				end
			end
		end
	end

	// verdict receiver and checker
	always @(posedge clk or negedge arst_n) begin
		verdict_word_t want;
		if (!arst_n) begin
			verdict_if.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (verdict_if.valid && verdict_if.ready) begin
				if (verdict_q.size() == 0) begin
					errors++;
					$display("%0t: verdict with none expected: balanced=%0b overflowed=%0b",
						$time, verdict_if.balanced, verdict_if.overflowed);
				end else begin
					want = verdict_q.pop_front();
					if (verdict_if.balanced !== want.balanced) begin
						errors++;
						$display("%0t: balanced expected %0b actual %0b",
							$time, want.balanced, verdict_if.balanced);
					end
					if (verdict_if.overflowed !== want.overflowed) begin
						errors++;
						$display("%0t: overflowed expected %0b actual %0b",
							$time, want.overflowed, verdict_if.overflowed);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				verdict_if.ready <= 1'b0;
			end else if (text_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 4);
				verdict_if.ready <= 1'b0;
			end else
				verdict_if.ready <= 1'b1;
		end
	end

	initial begin
		int unsigned roll;
		logic [7:0]  s[$];
		errors = 0;
		nest_level = 0;
		nest_mismatch = 1'b0;
		nest_overflow = 1'b0;
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.text_byte = 8'h00;
		chars_if.is_last = 1'b0;
		verdict_if.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero byte alone, all three pairs, stray closer, wrong closer,
		// all-ones byte, unclosed opener, zero byte inside a string, stray closer before a pair
		s = '{8'h00};
		queue_bytes(s);
		s = '{CHAR_LROUND, CHAR_LSQUARE, CHAR_LCURLY, CHAR_RCURLY, CHAR_RSQUARE, CHAR_RROUND};
		queue_bytes(s);
		s = '{CHAR_RROUND};
		queue_bytes(s);
		s = '{CHAR_LROUND, CHAR_RSQUARE};
		queue_bytes(s);
		s = '{8'hFF};
		queue_bytes(s);
		s = '{CHAR_LCURLY};
		queue_bytes(s);
		s = '{CHAR_LSQUARE, 8'h00, CHAR_RSQUARE};
		queue_bytes(s);
		s = '{CHAR_RCURLY, CHAR_LROUND, CHAR_RROUND};
		queue_bytes(s);

		// full stack, one past full, full then a stray closer, and a nested climb to full
		queue_tower(STACK_DEPTH, STACK_DEPTH, CODE_SQUARE);
		queue_tower(STACK_DEPTH + 1, STACK_DEPTH, CODE_ROUND);
		queue_tower(STACK_DEPTH, STACK_DEPTH + 1, CODE_CURLY);
		queue_nested(STACK_DEPTH, 1'b1, FLAW_NONE);

		// wait until every verdict so far is in before queueing random strings
		wait_idle();
		repeat ($urandom_range(3, 10)) @(posedge clk);

		while (text_q.size() < RANDOM_BYTES) begin
			roll = $urandom_range(0, 99);
			if (roll < 3)
				queue_nested($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4), 1'b1,
					flaw_t'($urandom_range(0, 1) ? FLAW_NONE : FLAW_SWAP));
			else if (roll < 73)
				queue_nested($urandom_range(1, 6), 1'b0, FLAW_NONE);
			else if (roll < 88)
				queue_nested($urandom_range(1, 6), 1'b0, flaw_t'($urandom_range(1, 4)));
			else
				queue_noise();
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0 && verdict_q.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
